### src/per_node_window_rate_limiter_defines.svh
// Assertion macros shared by the rate limiter RTL.
// Depends on nothing; included by the top level for its concurrent checks.
`ifndef PER_NODE_WINDOW_RATE_LIMITER_DEFINES_SVH
`define PER_NODE_WINDOW_RATE_LIMITER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PNWRL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rate limiter check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PNWRL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rate limiter check failed");

`endif

### src/pnwrl_pkg.sv
// Types and constants of the per-node window rate limiter.
// Depends on nothing; used by the top level.
package pnwrl_pkg;

    localparam int NODE_W    = 64;
    localparam int TIME_W    = 32;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 32;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PER_WINDOW = 1'd1;

    localparam logic [TIME_W-1:0]  WINDOW_MS_RESET  = 32'd10000;
    localparam logic [COUNT_W-1:0] PER_WINDOW_RESET = 8'd3;

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [TIME_W-1:0]  start;
        logic [COUNT_W-1:0] count;
    } slot_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_LAST,
        ST_DECIDE
    } state_t;

endpackage

### src/per_node_window_rate_limiter.sv
// Per-node fixed-window rate limiter: slot table in a synchronous memory.
// Depends on pnwrl_pkg and per_node_window_rate_limiter_defines.svh.
//
// Usage:
//   A request (node, now_ms) is taken at a clock edge with start high and busy
//   low. One result follows: done is high for exactly one cycle and allowed
//   holds the answer during that cycle. The receiver cannot stall the block.
//   Done rises after the scan, the LAST state and the DECIDE state; the result
//   is taken at the edge that ends the done cycle. Busy drops in the done
//   cycle, so a new request can be taken at that same edge; none is taken
//   while one is in flight. The pace is set by the single read port of the
//   slot memory: every slot is read once, one per cycle, then the LAST state
//   evaluates the last read, the DECIDE state decides and writes the chosen
//   slot back, and the block returns to idle.
//   Configuration: cfg_we with cfg_index selects window_ms (0) or per_window
//   (1); cfg_wdata is taken in the same edge. Write only while idle.
//   Reset (rst_n low, asynchronous) returns to idle, restores the register
//   defaults and clears the valid bit of every slot, so all slots read empty;
//   no clearing pass is needed.
module per_node_window_rate_limiter #(
    parameter int SLOT_COUNT = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pnwrl_pkg::NODE_W-1:0]        node,
    input  logic [pnwrl_pkg::TIME_W-1:0]        now_ms,
    output logic                                busy,
    output logic                                done,
    output logic                                allowed,
    input  logic                                cfg_we,
    input  logic [pnwrl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pnwrl_pkg::CFG_W-1:0]         cfg_wdata
);
    import pnwrl_pkg::*;

`include "per_node_window_rate_limiter_defines.svh"

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    slot_t mem [SLOT_COUNT];

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [NODE_W-1:0]    node_reg;
    logic [TIME_W-1:0]    now_reg;
    logic [TIME_W-1:0]    window_ms_reg;
    logic [COUNT_W-1:0]   per_window_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    slot_t                rd_data_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic                 chk_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     match_idx_reg;
    logic [TIME_W-1:0]    match_start_reg;
    logic [COUNT_W-1:0]   match_count_reg;
    logic                 free_found_reg;
    logic [IDX_W-1:0]     free_idx_reg;
    logic                 done_reg;
    logic                 allowed_reg;

    logic                 accept;
    logic [NODE_W-1:0]    rd_node;
    logic [TIME_W-1:0]    rd_elapsed;
    logic                 rd_match;
    logic                 rd_free;

    logic                 mem_we;
    logic [IDX_W-1:0]     wr_idx;
    slot_t                wr_entry;
    logic                 dec_allow;
    logic [TIME_W-1:0]    match_elapsed;
    logic [COUNT_W-1:0]   dec_count;
    logic [TIME_W-1:0]    dec_start;

    assign accept = start && (state_reg == ST_IDLE);

    // A slot whose valid bit is clear reads as the empty reset entry.
    assign rd_node    = rd_valid_reg ? rd_data_reg.node : '0;
    assign rd_elapsed = now_reg - rd_data_reg.start;
    assign rd_match   = (rd_node == node_reg);
    assign rd_free    = (rd_node == '0) || (rd_elapsed >= window_ms_reg);

    assign match_elapsed = now_reg - match_start_reg;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        mem_we     = 1'b0;
        wr_idx     = match_idx_reg;
        dec_count  = match_count_reg;
        dec_start  = match_start_reg;
        dec_allow  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                idx_next = '0;
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_LAST;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_LAST:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                state_next = ST_IDLE;
                if (node_reg != '0)
                begin
                    if (found_reg)
                    begin
                        wr_idx = match_idx_reg;
                        if (match_elapsed >= window_ms_reg)
                        begin
                            dec_count = '0;
                            dec_start = now_reg;
                        end
                        mem_we = 1'b1;
                    end
                    else if (free_found_reg)
                    begin
                        // A claimed slot starts a fresh window at now.
                        wr_idx    = free_idx_reg;
                        dec_count = '0;
                        dec_start = now_reg;
                        mem_we    = 1'b1;
                    end
                    dec_allow = mem_we && (dec_count < per_window_reg);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        wr_entry.node  = node_reg;
        wr_entry.start = dec_start;
        wr_entry.count = dec_allow ? COUNT_W'(dec_count + 1'b1) : dec_count;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            window_ms_reg  <= WINDOW_MS_RESET;
            per_window_reg <= PER_WINDOW_RESET;
            valid_reg      <= '0;
            chk_reg        <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            done_reg       <= 1'b0;
            allowed_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            chk_reg   <= (state_reg == ST_SCAN);
            done_reg  <= (state_reg == ST_DECIDE);
            if (state_reg == ST_DECIDE)
            begin
                allowed_reg <= dec_allow;
            end
            if (mem_we)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WINDOW_MS:  window_ms_reg  <= cfg_wdata;
                    REG_PER_WINDOW: per_window_reg <= cfg_wdata[COUNT_W-1:0];
                    default:        ;
                endcase
            end
            // Slots are read in ascending order, so the last hit is the highest.
            if (accept)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (chk_reg)
            begin
                if (rd_match)
                begin
                    found_reg <= 1'b1;
                end
                if (rd_free)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    // Request payload and per-scan captures need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            node_reg <= node;
            now_reg  <= now_ms;
        end
        if (chk_reg && rd_match)
        begin
            match_idx_reg   <= rd_idx_reg;
            match_start_reg <= rd_data_reg.start;
            match_count_reg <= rd_data_reg.count;
        end
        if (chk_reg && rd_free)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // Slot memory: one registered read and one write per cycle.
    always_ff @(posedge clk)
    begin
        rd_data_reg  <= mem[idx_reg];
        rd_valid_reg <= valid_reg[idx_reg];
        rd_idx_reg   <= idx_reg;
        if (mem_we)
        begin
            mem[wr_idx] <= wr_entry;
        end
    end

    assign busy    = (state_reg != ST_IDLE);
    assign done    = done_reg;
    assign allowed = allowed_reg;

    `PNWRL_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `PNWRL_ASSERT_NEXT(a_decide_done, clk, rst_n, state_reg == ST_DECIDE, done && !busy)
    `PNWRL_ASSERT_NEXT(a_zero_node_deny, clk, rst_n,
        state_reg == ST_DECIDE && node_reg == '0, !allowed)
    `PNWRL_ASSERT_NOW(a_allow_writes, clk, rst_n, dec_allow, mem_we)

endmodule
